// ----- rtl/core/plp_pkg.sv -----
package plp_pkg;

  // Per-item flags that ride along with the arithmetic
  typedef struct packed {
    logic degen;    // both end points coincide
    logic outside;  // u below 0 or above 1
    logic neg;      // dot product negative
  } plp_flags_t;

endpackage

// ----- rtl/core/point_line_projection_core.sv -----
// Point to line projection in 3D, signed fixed point, fully pipelined.
// Pipeline: 4 dot-product stages, a COORD_BITS+1 stage divider, 5 foot/distance stages,
// a COORD_BITS+1 stage root, one output.
// Throughput: one item per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous rst clears all valid bits; payload registers are not reset.
module point_line_projection_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] foot_x,
  output logic signed [COORD_BITS-1:0] foot_y,
  output logic signed [COORD_BITS-1:0] foot_z,
  output logic signed [COORD_BITS-1:0] line_param,
  output logic        [COORD_BITS-1:0] distance,
  output logic                         outside,
  output logic                         degenerate
);

  localparam int CB    = COORD_BITS;
  localparam int DB    = CB + 1;          // difference width
  localparam int PW    = 2 * DB;          // product of two differences
  localparam int MW    = 2 * CB + 2;      // magnitude of dot product / |B-A|^2
  localparam int NW    = MW + 1;          // signed dot product
  localparam int TW    = CB + DB;         // u * d
  localparam int FW    = TW + 2;          // foot before saturation
  localparam int SQW   = 2 * CB;          // squared distance term
  localparam int M     = CB + 1;          // root bits
  localparam int SIDE1 = 6 * CB + 3 * DB;
  localparam int SIDE2 = 4 * CB;

  localparam logic signed [FW-1:0] FMAX = (FW'(1) << (CB - 1)) - FW'(1);
  localparam logic signed [FW-1:0] FMIN = -FMAX - FW'(1);
  localparam logic [CB-1:0]        HALF = CB'(1) << (CB - 1);

  logic en;

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  logic signed [CB-1:0] pin [3];
  logic signed [CB-1:0] ain [3];
  logic signed [CB-1:0] bin [3];

  assign pin[0] = point_x;
  assign pin[1] = point_y;
  assign pin[2] = point_z;
  assign ain[0] = start_x;
  assign ain[1] = start_y;
  assign ain[2] = start_z;
  assign bin[0] = end_x;
  assign bin[1] = end_y;
  assign bin[2] = end_z;

  // stage registers
  logic                 v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic [SIDE1-1:0]     side1, side2, side3, side4, side5, side6, side7;
  logic signed [DB-1:0] pa1 [3];
  logic signed [PW-1:0] prodn2 [3];
  logic [PW-1:0]        prodd2 [3];
  logic signed [NW-1:0] num3;
  logic [MW-1:0]        den3, nmag4, den4;
  plp_pkg::plp_flags_t  flags4, flags5, flags6, flags7, flags8, flags9;
  logic signed [CB-1:0] u5, u6, u7, u8, u9;
  logic signed [TW-1:0] t6 [3];
  logic signed [CB-1:0] foot7 [3];
  logic signed [CB-1:0] foot8 [3];
  logic signed [CB-1:0] foot9 [3];
  logic [SQW-1:0]       sq8 [3];
  logic [2*M-1:0]       dist9;

  // divider outputs
  logic                div_valid, div_ovf;
  logic [CB-1:0]       div_q;
  plp_pkg::plp_flags_t div_flags;
  logic [SIDE1-1:0]    div_side;

  // side fields
  logic signed [CB-1:0] p7 [3];
  logic signed [CB-1:0] a6 [3];
  logic signed [DB-1:0] d1 [3];
  logic signed [DB-1:0] d5 [3];
  logic signed [DB-1:0] din [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      din[i] = DB'(bin[i]) - DB'(ain[i]);
      d1[i]  = side1[6*CB + i*DB +: DB];
      d5[i]  = side5[6*CB + i*DB +: DB];
      a6[i]  = side6[(3+i)*CB +: CB];
      p7[i]  = side7[i*CB +: CB];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= div_valid;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  // stages 1-4: differences, products, sums, sign split
  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= {din[2], din[1], din[0], ain[2], ain[1], ain[0], pin[2], pin[1], pin[0]};
      for (int i = 0; i < 3; i++) begin
        pa1[i]    <= DB'(pin[i]) - DB'(ain[i]);
        prodn2[i] <= pa1[i] * d1[i];
        prodd2[i] <= d1[i] * d1[i];
      end
      side2 <= side1;
      num3  <= NW'(prodn2[0]) + NW'(prodn2[1]) + NW'(prodn2[2]);
      den3  <= prodd2[0] + prodd2[1] + prodd2[2];
      side3 <= side2;
      nmag4 <= num3[NW-1] ? MW'(-num3) : MW'(num3);
      den4  <= den3;
      flags4.neg     <= num3[NW-1];
      flags4.degen   <= den3 == '0;
      flags4.outside <= num3[NW-1] || (MW'(num3) > den3);
      side4 <= side3;
    end
  end

  plp_div #(
    .CB(CB), .MW(MW), .FB(FRAC_BITS), .SIDE_W(SIDE1)
  ) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v4), .num(nmag4), .den(den4), .in_flags(flags4), .in_side(side4),
    .out_valid(div_valid), .quot(div_q), .ovf(div_ovf),
    .out_flags(div_flags), .out_side(div_side)
  );

  // saturate quotient and apply sign
  logic [CB-1:0] lim, qsat;

  always_comb begin
    lim  = div_flags.neg ? HALF : HALF - CB'(1);
    qsat = (div_ovf || div_q > lim) ? lim : div_q;
  end

  // foot point rounding and saturation, distance differences and squares
  logic signed [FW-1:0] rnd [3];
  logic signed [FW-1:0] fsum [3];
  logic signed [CB-1:0] foot_n [3];
  logic signed [DB-1:0] diff [3];
  logic signed [PW-1:0] sqf [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = FW'(t6[i]) + (FW'(1) << (FRAC_BITS - 1));
      fsum[i] = (rnd[i] >>> FRAC_BITS) + FW'(a6[i]);
      if (fsum[i] > FMAX) begin
        foot_n[i] = FMAX[CB-1:0];
      end else if (fsum[i] < FMIN) begin
        foot_n[i] = FMIN[CB-1:0];
      end else begin
        foot_n[i] = fsum[i][CB-1:0];
      end
      diff[i] = DB'(p7[i]) - DB'(foot7[i]);
      sqf[i]  = diff[i] * diff[i];
    end
  end

  // stages 5-9: u, u*d, foot, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      u5     <= div_flags.neg ? -qsat : qsat;
      flags5 <= div_flags;
      side5  <= div_side;
      for (int i = 0; i < 3; i++) begin
        t6[i]    <= u5 * d5[i];
        foot7[i] <= foot_n[i];
        sq8[i]   <= sqf[i][SQW-1:0];
        foot8[i] <= foot7[i];
        foot9[i] <= foot8[i];
      end
      u6     <= u5;
      flags6 <= flags5;
      side6  <= side5;
      u7     <= u6;
      flags7 <= flags6;
      side7  <= side6;
      u8     <= u7;
      flags8 <= flags7;
      dist9  <= (2*M)'(sq8[0]) + (2*M)'(sq8[1]) + (2*M)'(sq8[2]);
      u9     <= u8;
      flags9 <= flags8;
    end
  end

  logic                sq_valid;
  logic [M-1:0]        sq_root;
  plp_pkg::plp_flags_t sq_flags;
  logic [SIDE2-1:0]    sq_side;

  plp_sqrt #(
    .M(M), .SIDE_W(SIDE2)
  ) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v9), .rad(dist9), .in_flags(flags9),
    .in_side({u9, foot9[2], foot9[1], foot9[0]}),
    .out_valid(sq_valid), .root(sq_root), .out_flags(sq_flags), .out_side(sq_side)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= sq_flags.degen;
      if (sq_flags.degen) begin
        foot_x     <= '0;
        foot_y     <= '0;
        foot_z     <= '0;
        line_param <= '0;
        distance   <= '0;
        outside    <= 1'b0;
      end else begin
        foot_x     <= sq_side[0 +: CB];
        foot_y     <= sq_side[CB +: CB];
        foot_z     <= sq_side[2*CB +: CB];
        line_param <= sq_side[3*CB +: CB];
        distance   <= sq_root[M-1] ? '1 : sq_root[CB-1:0];
        outside    <= sq_flags.outside;
      end
    end
  end

endmodule

// ----- rtl/core/plp_div.sv -----
// Restoring divider: one quotient bit per stage, plus a leading overflow stage.
// Computes (num << FB) / den, CB quotient bits, ovf set when the quotient needs more.
module plp_div #(
  parameter int CB     = 32,
  parameter int MW     = 66,
  parameter int FB     = 16,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [MW-1:0]        num,
  input  logic [MW-1:0]        den,
  input  plp_pkg::plp_flags_t  in_flags,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [CB-1:0]        quot,
  output logic                 ovf,
  output plp_pkg::plp_flags_t  out_flags,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int RW = MW + CB + 1;
  localparam int NS = CB + 1;

  logic [RW-1:0]       rem  [CB];
  logic [MW-1:0]       dvs  [CB];
  logic                ge   [CB];
  logic [CB-1:0]       qs   [NS];
  logic                ovs  [NS];
  logic                vs   [NS];
  plp_pkg::plp_flags_t fs   [NS];
  logic [SIDE_W-1:0]   ss   [NS];

  // trial subtract decision per stage
  always_comb begin
    for (int k = 0; k < CB; k++) begin
      ge[k] = rem[k] >= (RW'(dvs[k]) << (CB - 1 - k));
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vs[k] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
      for (int k = 1; k < NS; k++) vs[k] <= vs[k-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num) << FB;
      dvs[0] <= den;
      qs[0]  <= '0;
      ovs[0] <= (RW'(num) << FB) >= (RW'(den) << CB);
      fs[0]  <= in_flags;
      ss[0]  <= in_side;
      for (int k = 1; k < CB; k++) begin
        rem[k] <= ge[k-1] ? rem[k-1] - (RW'(dvs[k-1]) << (CB - k)) : rem[k-1];
        dvs[k] <= dvs[k-1];
      end
      for (int k = 1; k < NS; k++) begin
        qs[k]  <= ge[k-1] ? (qs[k-1] | (CB'(1) << (CB - k))) : qs[k-1];
        ovs[k] <= ovs[k-1];
        fs[k]  <= fs[k-1];
        ss[k]  <= ss[k-1];
      end
    end
  end

  assign out_valid = vs[NS-1];
  assign quot      = qs[NS-1];
  assign ovf       = ovs[NS-1];
  assign out_flags = fs[NS-1];
  assign out_side  = ss[NS-1];

endmodule

// ----- rtl/core/plp_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per stage, rounded down.
module plp_sqrt #(
  parameter int M      = 33,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2*M-1:0]       rad,
  input  plp_pkg::plp_flags_t  in_flags,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [M-1:0]         root,
  output plp_pkg::plp_flags_t  out_flags,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int RW = M + 3;

  logic [RW-1:0]       rem_r   [M-1];
  logic [2*M-1:0]      rad_r   [M-1];
  logic [M-1:0]        root_r  [M];
  logic                v_r     [M];
  plp_pkg::plp_flags_t flags_r [M];
  logic [SIDE_W-1:0]   side_r  [M];

  logic [RW-1:0]       src_rem  [M];
  logic [M-1:0]        src_root [M];
  logic [2*M-1:0]      src_rad  [M];
  logic [RW-1:0]       x        [M];
  logic [RW-1:0]       tr       [M];
  logic                ge       [M];
  logic [RW-1:0]       rem_n    [M];
  logic [M-1:0]        root_n   [M];

  // stage inputs and trial subtract
  always_comb begin
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_rad[0]  = rad;
    for (int j = 1; j < M; j++) begin
      src_rem[j]  = rem_r[j-1];
      src_root[j] = root_r[j-1];
      src_rad[j]  = rad_r[j-1];
    end
    for (int j = 0; j < M; j++) begin
      x[j]      = (src_rem[j] << 2) | RW'(src_rad[j][2*(M-1-j) +: 2]);
      tr[j]     = (RW'(src_root[j]) << 2) | RW'(1);
      ge[j]     = x[j] >= tr[j];
      rem_n[j]  = ge[j] ? x[j] - tr[j] : x[j];
      root_n[j] = {src_root[j][M-2:0], ge[j]};
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < M; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int j = 1; j < M; j++) v_r[j] <= v_r[j-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      flags_r[0] <= in_flags;
      side_r[0]  <= in_side;
      for (int j = 1; j < M; j++) begin
        flags_r[j] <= flags_r[j-1];
        side_r[j]  <= side_r[j-1];
      end
      for (int j = 0; j < M; j++) root_r[j] <= root_n[j];
      for (int j = 0; j < M - 1; j++) begin
        rem_r[j] <= rem_n[j];
        rad_r[j] <= src_rad[j];
      end
    end
  end

  assign out_valid = v_r[M-1];
  assign root      = root_r[M-1];
  assign out_flags = flags_r[M-1];
  assign out_side  = side_r[M-1];

endmodule

// ----- rtl/core/plp_checker.sv -----
// Port-level checks for the projection core.
module plp_checker #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] foot_x,
  input logic signed [COORD_BITS-1:0] foot_y,
  input logic signed [COORD_BITS-1:0] foot_z,
  input logic signed [COORD_BITS-1:0] line_param,
  input logic        [COORD_BITS-1:0] distance,
  input logic                         outside,
  input logic                         degenerate
);

  localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1) << FRAC_BITS;

  // input side stalls only while a finished item is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held output");

  // held item stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_param) && $stable(distance))
    else $error("held item changed");

  // coinciding end points give zeros
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> foot_x == '0 && foot_y == '0 && foot_z == '0 &&
      line_param == '0 && distance == '0 && !outside)
    else $error("degenerate item has nonzero fields");

  // negative u lies outside the segment
  a_neg_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate && line_param[COORD_BITS-1] |-> outside)
    else $error("negative u not flagged outside");

  // u above one lies outside the segment
  a_big_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate && (line_param > ONE) |-> outside)
    else $error("u above one not flagged outside");

endmodule

bind point_line_projection_core plp_checker #(
  .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)
) u_plp_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z),
  .line_param(line_param), .distance(distance), .outside(outside),
  .degenerate(degenerate)
);
